FILE: rtl/gsr_pkg.sv
package gsr_pkg;

	typedef logic [7:0] byte_t;
	typedef byte_t byte6_t [6];

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_ABORT = 2'd2,
		ACT_RESET = 2'd3
	} action_t;

	typedef struct packed {
		logic [7:0] reply;
		logic       ack;
		logic       done;
		logic [4:0] pos;
	} result_t;

	localparam byte_t MODE_DIG = 8'h41;
	localparam byte_t MODE_ANA = 8'h73;
	localparam byte_t MODE_NAT = 8'h79;
	localparam byte_t ID_CONFIG = 8'hf3;
	localparam byte_t ID_TAIL   = 8'h5a;
	localparam byte_t IDLE_BYTE = 8'hff;

	localparam byte_t CMD_STATUS    = 8'h40;
	localparam byte_t CMD_MASK_QRY  = 8'h41;
	localparam byte_t CMD_POLL      = 8'h42;
	localparam byte_t CMD_CONFIG    = 8'h43;
	localparam byte_t CMD_SET_MODE  = 8'h44;
	localparam byte_t CMD_MODEL     = 8'h45;
	localparam byte_t CMD_ACT_INFO  = 8'h46;
	localparam byte_t CMD_COMB_INFO = 8'h47;
	localparam byte_t CMD_MODE_INFO = 8'h4c;
	localparam byte_t CMD_MOTOR     = 8'h4d;
	localparam byte_t CMD_NATIVE    = 8'h4f;

	localparam logic [4:0] LEN_DIG = 5'd5;
	localparam logic [4:0] LEN_ANA = 5'd9;
	localparam logic [4:0] LEN_NAT = 5'd21;

	localparam int RESP_LEN = 6;
	localparam int BUF_LEN  = 18;

	localparam byte6_t T_STATUS = '{8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h5a};
	localparam byte6_t T_MODEL  = '{8'h03, 8'h02, 8'h00, 8'h02, 8'h01, 8'h00};
	localparam byte6_t T_ACT0   = '{8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h0a};
	localparam byte6_t T_ACT1   = '{8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h14};
	localparam byte6_t T_COMB   = '{8'h00, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00};
	localparam byte6_t T_MODE0  = '{8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00};
	localparam byte6_t T_MODE1  = '{8'h00, 8'h00, 8'h00, 8'h07, 8'h00, 8'h00};
	localparam byte6_t T_NATIVE = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5a};

endpackage

FILE: rtl/gamepad_serial_responder_top.sv
// Controller-side byte responder for a gamepad serial link. Each input word is an action
// (start, command byte, abort, reset) with the host's command byte; each one yields exactly one
// output word: the reply byte for the next position, an ack request, a done flag on tlast and the
// byte position. One word is accepted every cycle while the master side is not stalled; each word
// passes the input register and then the result register before it is offered on the master side:
// the whole per-byte decode, including the six-byte table loads into the response buffer, runs in
// one pass between the input register and the result register. s_tready follows m_tready through
// the input stage, so a stalled output holds the input register and then the slave side.
module gamepad_serial_responder_top import gsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] command_byte
	input  logic [1:0]  s_tuser,  // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] reply_byte, [8] send_ack, [13:9] byte_position, zero pad
	output logic        m_tlast   // transaction_done
);

	logic    vld_s1;
	action_t act_s1;
	byte_t   byte_s1;
	logic    out_vld_q;
	result_t out_res_q;
	result_t res;
	logic    adv;

	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			act_s1  <= action_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
	end

	gsr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.action    (act_s1),
		.host_byte (byte_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_res_q <= res;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_res_q.pos, out_res_q.ack, out_res_q.reply};
	assign m_tlast  = out_res_q.done;

	// a word waiting in the input stage is held while the output is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && out_vld_q && !m_tready |=> vld_s1 && $stable(act_s1) && $stable(byte_s1))
		else $error("input stage lost a word under output stall");

	// a result only appears from a word in the input stage
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(vld_s1))
		else $error("result without a source word");

	// an ack is never requested on the word that ends a transaction
	a_ack_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_res_q.done |-> !out_res_q.ack && out_res_q.reply == IDLE_BYTE)
		else $error("ack or reply data on a closing word");

endmodule

FILE: rtl/gsr_core.sv
module gsr_core import gsr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  action_t action,
	input  byte_t   host_byte,
	output result_t res
);

	byte_t      mode_q, mode_d;
	logic       cfg_q, cfg_d;
	byte_t      pend_mode_q, pend_mode_d;
	logic       pend_cfg_q, pend_cfg_d;
	byte_t      motor_q [6];
	byte_t      motor_d [6];
	logic       lock_q, lock_d;
	byte_t      mask_q [3];
	byte_t      mask_d [3];
	byte_t      rbuf_q [BUF_LEN];
	byte_t      rbuf_d [BUF_LEN];
	byte_t      cmd_q, cmd_d;
	logic [4:0] cnt_q, cnt_d;
	logic [4:0] flen_q, flen_d;
	logic       in_tx_q, in_tx_d;

	logic [4:0] idx, rp;
	logic [2:0] off;

	always_comb begin
		mode_d      = mode_q;
		cfg_d       = cfg_q;
		pend_mode_d = pend_mode_q;
		pend_cfg_d  = pend_cfg_q;
		motor_d     = motor_q;
		lock_d      = lock_q;
		mask_d      = mask_q;
		rbuf_d      = rbuf_q;
		cmd_d       = cmd_q;
		cnt_d       = cnt_q;
		flen_d      = flen_q;
		in_tx_d     = in_tx_q;
		res         = '{reply: IDLE_BYTE, ack: 1'b0, done: 1'b0, pos: 5'd0};
		idx         = cnt_q;
		rp          = cnt_q + 5'd1;
		off         = 3'(cnt_q - 5'd3);

		if (fire) begin
			unique case (action)
				ACT_START: begin
					if (in_tx_q) begin
						mode_d = pend_mode_q;
						cfg_d  = pend_cfg_q;
					end
					if (cfg_d || mode_d == MODE_ANA) flen_d = LEN_ANA;
					else if (mode_d == MODE_NAT) flen_d = LEN_NAT;
					else flen_d = LEN_DIG;
					cnt_d   = 5'd0;
					in_tx_d = 1'b1;
				end
				ACT_ABORT: begin
					if (in_tx_q) begin
						mode_d   = pend_mode_q;
						cfg_d    = pend_cfg_q;
						in_tx_d  = 1'b0;
						res.done = 1'b1;
						res.pos  = cnt_q;
					end
				end
				ACT_RESET: begin
					mode_d      = MODE_DIG;
					cfg_d       = 1'b0;
					pend_mode_d = MODE_DIG;
					pend_cfg_d  = 1'b0;
					for (int i = 0; i < 6; i++) motor_d[i] = 8'hff;
					lock_d    = 1'b0;
					mask_d[0] = 8'hff;
					mask_d[1] = 8'hff;
					mask_d[2] = 8'h03;
					in_tx_d   = 1'b0;
					cnt_d     = 5'd0;
				end
				ACT_BYTE: begin
					if (!in_tx_q || cnt_q >= flen_q) begin
						in_tx_d = 1'b0;
					end else begin
						if (idx == 5'd1) begin
							cmd_d = host_byte;
							case (host_byte) inside
								CMD_STATUS:
									for (int i = 0; i < RESP_LEN; i++) rbuf_d[i] = T_STATUS[i];
								CMD_MASK_QRY: begin
									for (int i = 0; i < RESP_LEN; i++) rbuf_d[i] = 8'h00;
									if (mode_q != MODE_DIG) begin
										rbuf_d[0] = mask_q[0];
										rbuf_d[1] = mask_q[1];
										rbuf_d[2] = mask_q[2];
										rbuf_d[5] = ID_TAIL;
									end
								end
								CMD_POLL, CMD_CONFIG:
									for (int i = 0; i < BUF_LEN; i++) rbuf_d[i] = 8'h00;
								CMD_SET_MODE:
									for (int i = 0; i < RESP_LEN; i++) rbuf_d[i] = 8'h00;
								CMD_MODEL: begin
									for (int i = 0; i < RESP_LEN; i++) rbuf_d[i] = T_MODEL[i];
									rbuf_d[2] = (mode_q != MODE_DIG) ? 8'h01 : 8'h00;
								end
								CMD_ACT_INFO, CMD_MODE_INFO:
									rbuf_d[0] = 8'h00;
								CMD_COMB_INFO:
									for (int i = 0; i < RESP_LEN; i++) rbuf_d[i] = T_COMB[i];
								CMD_MOTOR:
									for (int i = 0; i < RESP_LEN; i++) rbuf_d[i] = motor_q[i];
								CMD_NATIVE: begin
									pend_mode_d = MODE_NAT;
									for (int i = 0; i < RESP_LEN; i++) rbuf_d[i] = T_NATIVE[i];
								end
								default:
									for (int i = 0; i < BUF_LEN; i++) rbuf_d[i] = 8'hff;
							endcase
						end else begin
							if (idx == 5'd3) begin
								if (cmd_q == CMD_CONFIG) pend_cfg_d = (host_byte == 8'h01);
								if (cmd_q == CMD_SET_MODE)
									pend_mode_d = (host_byte != 8'h00) ? MODE_ANA : MODE_DIG;
								// pages other than 0 and 1 leave the buffer alone
								if (cmd_q == CMD_ACT_INFO) begin
									if (host_byte == 8'h00)
										for (int i = 0; i < RESP_LEN; i++) rbuf_d[i] = T_ACT0[i];
									else if (host_byte == 8'h01)
										for (int i = 0; i < RESP_LEN; i++) rbuf_d[i] = T_ACT1[i];
								end
								if (cmd_q == CMD_MODE_INFO) begin
									if (host_byte == 8'h00)
										for (int i = 0; i < RESP_LEN; i++) rbuf_d[i] = T_MODE0[i];
									else if (host_byte == 8'h01)
										for (int i = 0; i < RESP_LEN; i++) rbuf_d[i] = T_MODE1[i];
								end
							end
							if (idx == 5'd4 && cmd_q == CMD_SET_MODE) lock_d = (host_byte != 8'h00);
							if (cmd_q == CMD_MOTOR && idx >= 5'd3 && idx <= 5'd8)
								motor_d[off] = host_byte;
							if (cmd_q == CMD_NATIVE && idx >= 5'd3 && idx <= 5'd5)
								mask_d[off[1:0]] = host_byte;
						end

						cnt_d   = rp;
						res.pos = idx;
						if (rp >= flen_q) begin
							// last word of the frame commits pending state
							mode_d   = pend_mode_d;
							cfg_d    = pend_cfg_d;
							in_tx_d  = 1'b0;
							res.done = 1'b1;
						end else begin
							res.ack = 1'b1;
							if (rp == 5'd1) res.reply = cfg_q ? ID_CONFIG : mode_q;
							else if (rp == 5'd2) res.reply = ID_TAIL;
							else if (rp >= 5'd3 && rp <= 5'd20) res.reply = rbuf_d[rp - 5'd3];
							else res.reply = IDLE_BYTE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_DIG;
			cfg_q       <= 1'b0;
			pend_mode_q <= MODE_DIG;
			pend_cfg_q  <= 1'b0;
			for (int i = 0; i < 6; i++) motor_q[i] <= 8'hff;
			lock_q    <= 1'b0;
			mask_q[0] <= 8'hff;
			mask_q[1] <= 8'hff;
			mask_q[2] <= 8'h03;
			for (int i = 0; i < BUF_LEN; i++) rbuf_q[i] <= 8'h00;
			cmd_q   <= 8'h00;
			cnt_q   <= 5'd0;
			flen_q  <= LEN_DIG;
			in_tx_q <= 1'b0;
		end else begin
			mode_q      <= mode_d;
			cfg_q       <= cfg_d;
			pend_mode_q <= pend_mode_d;
			pend_cfg_q  <= pend_cfg_d;
			motor_q     <= motor_d;
			lock_q      <= lock_d;
			mask_q      <= mask_d;
			rbuf_q      <= rbuf_d;
			cmd_q       <= cmd_d;
			cnt_q       <= cnt_d;
			flen_q      <= flen_d;
			in_tx_q     <= in_tx_d;
		end
	end

endmodule

FILE: tb/tb.sv
module tb;
	import gsr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_WORDS   = 800;
	localparam int HOLD_LONG = 48;

	typedef struct packed {
		action_t act;
		byte_t   cmd;
		logic    fixed;
		result_t want;
	} step_t;

	localparam result_t IDLE_R = '{IDLE_BYTE, 1'b0, 1'b0, 5'd0};

	// short directed walk: idle traffic, a native switch, a config entry by abort,
	// a page outside 0/1, a restart while open, an unknown command and a state reset
	localparam step_t PLAN [25] = '{
		'{ACT_BYTE,  8'hff, 1'b1, IDLE_R},
		'{ACT_ABORT, 8'h00, 1'b1, IDLE_R},
		'{ACT_START, 8'h00, 1'b1, IDLE_R},
		'{ACT_BYTE,  8'h01, 1'b1, '{MODE_DIG, 1'b1, 1'b0, 5'd0}},
		'{ACT_BYTE,  8'h4f, 1'b1, '{ID_TAIL, 1'b1, 1'b0, 5'd1}},
		'{ACT_BYTE,  8'h00, 1'b0, '0},
		'{ACT_BYTE,  8'hff, 1'b0, '0},
		'{ACT_BYTE,  8'h00, 1'b1, '{IDLE_BYTE, 1'b0, 1'b1, 5'd4}},
		'{ACT_START, 8'h00, 1'b1, IDLE_R},
		'{ACT_BYTE,  8'h01, 1'b1, '{MODE_NAT, 1'b1, 1'b0, 5'd0}},
		'{ACT_BYTE,  8'h43, 1'b1, '{ID_TAIL, 1'b1, 1'b0, 5'd1}},
		'{ACT_BYTE,  8'h00, 1'b0, '0},
		'{ACT_BYTE,  8'h01, 1'b0, '0},
		'{ACT_ABORT, 8'h00, 1'b1, '{IDLE_BYTE, 1'b0, 1'b1, 5'd4}},
		'{ACT_START, 8'h00, 1'b1, IDLE_R},
		'{ACT_BYTE,  8'h01, 1'b1, '{ID_CONFIG, 1'b1, 1'b0, 5'd0}},
		'{ACT_BYTE,  8'h46, 1'b0, '0},
		'{ACT_BYTE,  8'h00, 1'b0, '0},
		'{ACT_BYTE,  8'h02, 1'b0, '0},
		'{ACT_START, 8'h00, 1'b1, IDLE_R},
		'{ACT_BYTE,  8'h01, 1'b0, '0},
		'{ACT_BYTE,  8'hee, 1'b0, '0},
		'{ACT_BYTE,  8'h00, 1'b0, '0},
		'{ACT_RESET, 8'h00, 1'b1, IDLE_R},
		'{ACT_BYTE,  8'h01, 1'b1, IDLE_R}
	};

	localparam byte_t CMD_SET [11] = '{CMD_STATUS, CMD_MASK_QRY, CMD_POLL, CMD_CONFIG,
		CMD_SET_MODE, CMD_MODEL, CMD_ACT_INFO, CMD_COMB_INFO, CMD_MODE_INFO, CMD_MOTOR,
		CMD_NATIVE};

	localparam byte_t STATUS_ROW [6] = '{8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h5a};
	localparam byte_t MODEL_ROW  [6] = '{8'h03, 8'h02, 8'h00, 8'h02, 8'h01, 8'h00};
	localparam byte_t ACT0_ROW   [6] = '{8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h0a};
	localparam byte_t ACT1_ROW   [6] = '{8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h14};
	localparam byte_t COMB_ROW   [6] = '{8'h00, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00};
	localparam byte_t MODE0_ROW  [6] = '{8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00};
	localparam byte_t MODE1_ROW  [6] = '{8'h00, 8'h00, 8'h00, 8'h07, 8'h00, 8'h00};
	localparam byte_t NATIVE_ROW [6] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5a};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] command_byte
	logic [1:0]  s_tuser = '0;   // [1:0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [7:0] reply_byte, [8] send_ack, [13:9] byte_position
	logic        m_tlast;        // transaction_done

	// controller state as seen from the host
	byte_t      cur_mode, next_mode, held_cmd;
	logic       cfg_on, next_cfg, in_frame;
	byte_t      motor [6];
	byte_t      mask [3];
	byte_t      rbuf [18];
	logic [4:0] count_in, frame_len;

	result_t replies_due [$];
	int      n_sent = 0, n_closed = 0, errors = 0;
	int      n_nat = 0, n_ana = 0, n_cfg = 0;
	logic    calm = 1'b0, long_hold = 1'b0;

	gamepad_serial_responder_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic void restore_pad();
		cur_mode  = MODE_DIG;
		cfg_on    = 1'b0;
		next_mode = MODE_DIG;
		next_cfg  = 1'b0;
		foreach (motor[i]) motor[i] = 8'hff;
		mask = '{8'hff, 8'hff, 8'h03};
	endfunction

	function automatic void land_pending();
		cfg_on   = next_cfg;
		cur_mode = next_mode;
		in_frame = 1'b0;
	endfunction

	function automatic byte_t reply_for(input int pos);
		if (pos == 0) return IDLE_BYTE;
		if (pos == 1) return cfg_on ? ID_CONFIG : cur_mode;
		if (pos == 2) return ID_TAIL;
		if (pos <= 20) return rbuf[pos - 3];
		return IDLE_BYTE;
	endfunction

	function automatic void load_row(input byte_t row [6]);
		for (int i = 0; i < 6; i++) rbuf[i] = row[i];
	endfunction

	function automatic void take_byte(input int idx, input byte_t b);
		if (idx == 1) begin
			held_cmd = b;
			case (b)
				CMD_STATUS: load_row(STATUS_ROW);
				CMD_MASK_QRY: begin
					for (int i = 0; i < 6; i++) rbuf[i] = 8'h00;
					if (cur_mode != MODE_DIG) begin
						for (int i = 0; i < 3; i++) rbuf[i] = mask[i];
						rbuf[5] = ID_TAIL;
					end
				end
				CMD_POLL, CMD_CONFIG: foreach (rbuf[i]) rbuf[i] = 8'h00;
				CMD_SET_MODE: for (int i = 0; i < 6; i++) rbuf[i] = 8'h00;
				CMD_MODEL: begin
					load_row(MODEL_ROW);
					rbuf[2] = (cur_mode != MODE_DIG) ? 8'h01 : 8'h00;
				end
				CMD_ACT_INFO, CMD_MODE_INFO: rbuf[0] = 8'h00;
				CMD_COMB_INFO: load_row(COMB_ROW);
				CMD_MOTOR: load_row(motor);
				CMD_NATIVE: begin
					next_mode = MODE_NAT;
					load_row(NATIVE_ROW);
				end
				default: foreach (rbuf[i]) rbuf[i] = 8'hff;
			endcase
			return;
		end
		if (idx == 3) begin
			if (held_cmd == CMD_CONFIG) next_cfg = (b == 8'h01);
			if (held_cmd == CMD_SET_MODE) next_mode = (b != 8'h00) ? MODE_ANA : MODE_DIG;
			// pages other than 0 and 1 leave the buffer alone
			if (held_cmd == CMD_ACT_INFO && b == 8'h00) load_row(ACT0_ROW);
			if (held_cmd == CMD_ACT_INFO && b == 8'h01) load_row(ACT1_ROW);
			if (held_cmd == CMD_MODE_INFO && b == 8'h00) load_row(MODE0_ROW);
			if (held_cmd == CMD_MODE_INFO && b == 8'h01) load_row(MODE1_ROW);
		end
		if (held_cmd == CMD_MOTOR && idx >= 3 && idx < 9) motor[idx - 3] = b;
		if (held_cmd == CMD_NATIVE && idx >= 3 && idx < 6) mask[idx - 3] = b;
	endfunction

	function automatic result_t pad_reply(input action_t act, input byte_t b);
		int idx;
		case (act)
			ACT_START: begin
				if (in_frame) land_pending();
				if (cfg_on) begin
					frame_len = LEN_ANA;
					n_cfg++;
				end else if (cur_mode == MODE_ANA) begin
					frame_len = LEN_ANA;
					n_ana++;
				end else if (cur_mode == MODE_NAT) begin
					frame_len = LEN_NAT;
					n_nat++;
				end else begin
					frame_len = LEN_DIG;
				end
				count_in = 5'd0;
				in_frame = 1'b1;
				return IDLE_R;
			end
			ACT_ABORT: begin
				if (!in_frame) return IDLE_R;
				land_pending();
				return '{IDLE_BYTE, 1'b0, 1'b1, count_in};
			end
			ACT_RESET: begin
				restore_pad();
				in_frame = 1'b0;
				count_in = 5'd0;
				return IDLE_R;
			end
			default: begin
				if (!in_frame || count_in >= frame_len) begin
					in_frame = 1'b0;
					return IDLE_R;
				end
				idx = count_in;
				take_byte(idx, b);
				count_in = 5'(idx + 1);
				if (idx + 1 >= frame_len) begin
					land_pending();
					return '{IDLE_BYTE, 1'b0, 1'b1, 5'(idx)};
				end
				return '{reply_for(idx + 1), 1'b1, 1'b0, 5'(idx)};
			end
		endcase
	endfunction

	task automatic push_word(input action_t act, input byte_t b, input logic fixed,
			input result_t want);
		result_t guess;
		if (!calm && !long_hold && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		guess = pad_reply(act, b);
		replies_due.push_back(fixed ? want : guess);
		n_sent++;
	endtask

	// host side read-back with random stalls and one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (HOLD_LONG) @(posedge clk);
				long_hold = 1'b0;
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[7:0], m_tdata[8], m_tlast, m_tdata[13:9]};
			if (got.done) n_closed++;
			if (replies_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: reply %02h ack %0d done %0d pos %0d",
						got.reply, got.ack, got.done, got.pos);
			end else begin
				want = replies_due.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch (exp/act): reply %02h/%02h ack %0d/%0d done %0d/%0d pos %0d/%0d",
							want.reply, got.reply, want.ack, got.ack,
							want.done, got.done, want.pos, got.pos);
				end
			end
		end
	end

	initial begin
		int len, cut, pick;
		byte_t cmd, b;
		logic held;
		held = 1'b0;
		restore_pad();
		foreach (rbuf[i]) rbuf[i] = 8'h00;
		held_cmd  = 8'h00;
		count_in  = 5'd0;
		frame_len = LEN_DIG;
		in_frame  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i]) push_word(PLAN[i].act, PLAN[i].cmd, PLAN[i].fixed, PLAN[i].want);

		// sender stands still until the pipe has drained
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		@(posedge clk);

		while (n_sent < N_WORDS) begin
			if (n_sent > N_WORDS - 100) calm = 1'b1;
			if (!held && n_sent > 300) begin
				long_hold = 1'b1;
				held = 1'b1;
			end
			pick = $urandom_range(0, 39);
			if (pick < 34) begin
				push_word(ACT_START, byte_t'($urandom), 1'b0, '0);
				len = frame_len;
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
				cmd = ($urandom_range(0, 4) == 0) ? byte_t'($urandom)
					: CMD_SET[$urandom_range(0, 10)];
				for (int k = 0; k < cut; k++) begin
					case (k)
						0: b = ($urandom_range(0, 7) == 0) ? byte_t'($urandom) : 8'h01;
						1: b = cmd;
						3: b = ($urandom_range(0, 2) == 0) ? byte_t'($urandom)
							: byte_t'($urandom_range(0, 1));
						default: b = ($urandom_range(0, 3) == 0) ? 8'h00 : byte_t'($urandom);
					endcase
					push_word(ACT_BYTE, b, 1'b0, '0);
				end
				if (cut < len)
					push_word($urandom_range(0, 1) ? ACT_ABORT : ACT_START,
						byte_t'($urandom), 1'b0, '0);
			end else begin
				push_word(action_t'($urandom_range(0, 3)), byte_t'($urandom), 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		while (replies_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d words sent, %0d frames closed by last byte or abort", n_sent, n_closed);
		$display("frames opened in native %0d, analog %0d, config %0d", n_nat, n_ana, n_cfg);
		if (errors == 0 && replies_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/gsr_pkg.sv
rtl/gsr_core.sv
rtl/gamepad_serial_responder_top.sv
tb/tb.sv
